[hdl/ifkc_pkg.sv]
package ifkc_pkg;

    localparam logic [1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] CLASS_IPV4 = 2'd1;
    localparam logic [1:0] CLASS_FLOW = 2'd2;

    localparam logic [1:0] NEED_NONE  = 2'd0;
    localparam logic [1:0] NEED_ICMP  = 2'd1;
    localparam logic [1:0] NEED_PORTS = 2'd2;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] wire_length;
        logic [31:0] now_time;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]  packet_class;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  protocol;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        multicast;
        logic        from_fragment_entry;
        logic [15:0] length_out;
    } result_item_t;

    typedef struct packed {
        logic        ip_ok;
        logic        fragd;
        logic        l4_ok;
        logic [1:0]  need;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] ip_id;
        logic [7:0]  protocol;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        multicast;
        logic [15:0] length;
        logic [31:0] now_time;
    } desc_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] ip_id;
        logic [7:0]  protocol;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] stamp;
    } entry_t;

endpackage

[hdl/ifkc_front.sv]
module ifkc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_valid,
    output logic                    byte_ready,
    input  ifkc_pkg::byte_item_t    byte_data,
    input  logic                    cfg_we,
    input  logic [15:0]             cfg_wdata,
    input  logic                    queue_ready,
    input  logic                    table_busy,
    output logic                    push,
    output ifkc_pkg::desc_t         desc
);

    localparam logic [3:0] PH_ETH    = 4'd0;
    localparam logic [3:0] PH_VLAN   = 4'd1;
    localparam logic [3:0] PH_LLC    = 4'd2;
    localparam logic [3:0] PH_SNAP   = 4'd3;
    localparam logic [3:0] PH_PPPOE  = 4'd4;
    localparam logic [3:0] PH_IP     = 4'd5;
    localparam logic [3:0] PH_IPDONE = 4'd6;
    localparam logic [3:0] PH_REJECT = 4'd7;

    logic [15:0] max_len_reg;
    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [15:0] et_reg, et_next;
    logic        mc_reg, mc_next;
    logic [7:0]  llc0_reg, llc0_next, llc1_reg, llc1_next;
    logic [7:0]  vihl_reg, vihl_next;
    logic [15:0] id_reg, id_next, frag_reg, frag_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next, dst_reg, dst_next, l4_reg, l4_next;

    logic [7:0]  b;
    logic [15:0] et_full;
    logic [7:0]  vihl_eff;
    logic [8:0]  pos9, hl9, l4_off;
    logic        accept;
    logic [3:0]  fb_phase;
    logic [8:0]  hl_n, l4n;
    logic [1:0]  need;
    logic [8:0]  need9;

    function automatic logic [3:0] tail_ph(input logic [15:0] et);
        if (et == 16'h8864)
            return PH_PPPOE;
        else if (et == 16'h0800)
            return PH_IP;
        else
            return PH_REJECT;
    endfunction

    assign b          = byte_data.data_byte;
    assign et_full    = {et_reg[15:8], b};
    assign byte_ready = queue_ready && !table_busy;
    assign accept     = byte_valid && byte_ready;
    assign push       = accept && byte_data.last_byte;
    assign pos9       = {1'b0, pos_reg};

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg + 8'd1;
        et_next    = et_reg;
        mc_next    = mc_reg;
        llc0_next  = llc0_reg;
        llc1_next  = llc1_reg;
        vihl_next  = vihl_reg;
        id_next    = id_reg;
        frag_next  = frag_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        l4_next    = l4_reg;
        vihl_eff   = (pos_reg == 8'd0) ? b : vihl_reg;
        hl9        = {3'b000, vihl_eff[3:0], 2'b00};
        l4_off     = pos9 - hl9;
        fb_phase   = PH_REJECT;
        unique case (phase_reg)
            PH_ETH:
            begin
                if (pos_reg == 8'd0)
                    mc_next = b[0];
                if (pos_reg == 8'd12)
                    et_next = {b, 8'h00};
                if (pos_reg == 8'd13)
                begin
                    et_next  = et_full;
                    pos_next = 8'd0;
                    if (et_full == 16'h8100)
                        phase_next = PH_VLAN;
                    else if (et_full <= max_len_reg)
                        phase_next = PH_LLC;
                    else
                        phase_next = tail_ph(et_full);
                end
            end
            PH_VLAN:
            begin
                if (pos_reg == 8'd2)
                    et_next = {b, 8'h00};
                if (pos_reg == 8'd3)
                begin
                    et_next  = et_full;
                    pos_next = 8'd0;
                    if (et_full <= max_len_reg)
                        phase_next = PH_LLC;
                    else
                        phase_next = tail_ph(et_full);
                end
            end
            PH_LLC:
            begin
                if (pos_reg == 8'd0)
                    llc0_next = b;
                if (pos_reg == 8'd1)
                    llc1_next = b;
                if (pos_reg == 8'd2)
                begin
                    pos_next = 8'd0;
                    if (llc0_reg == 8'hAA && llc1_reg == 8'hAA && b == 8'h03)
                        phase_next = PH_SNAP;
                    else if (llc0_reg == 8'h06 && llc1_reg == 8'h06 && b[0])
                    begin
                        et_next    = 16'h0800;
                        phase_next = PH_IP;
                    end
                    else
                    begin
                        // The three LLC bytes are parsed again as the start of the header.
                        fb_phase = tail_ph(et_reg);
                        if (fb_phase == PH_PPPOE)
                        begin
                            phase_next = PH_PPPOE;
                            pos_next   = 8'd3;
                        end
                        else if (fb_phase == PH_IP &&
                                 llc0_reg[7:4] == 4'd4 && llc0_reg[3:0] >= 4'd5)
                        begin
                            phase_next = PH_IP;
                            vihl_next  = llc0_reg;
                            pos_next   = 8'd3;
                        end
                        else
                            phase_next = PH_REJECT;
                    end
                end
            end
            PH_SNAP:
            begin
                if (pos_reg < 8'd3)
                begin
                    if (b != 8'd0)
                    begin
                        phase_next = PH_REJECT;
                        pos_next   = 8'd0;
                    end
                end
                else if (pos_reg == 8'd3)
                    et_next = {b, 8'h00};
                else
                begin
                    et_next    = et_full;
                    pos_next   = 8'd0;
                    phase_next = tail_ph(et_full);
                end
            end
            PH_PPPOE:
            begin
                if (pos_reg == 8'd6 && b != 8'd0)
                begin
                    phase_next = PH_REJECT;
                    pos_next   = 8'd0;
                end
                if (pos_reg == 8'd7)
                begin
                    pos_next = 8'd0;
                    if (b == 8'h21)
                    begin
                        et_next    = 16'h0800;
                        phase_next = PH_IP;
                    end
                    else
                        phase_next = PH_REJECT;
                end
            end
            PH_IP:
            begin
                if (pos_reg == 8'd0 && (b[7:4] != 4'd4 || b[3:0] < 4'd5))
                begin
                    phase_next = PH_REJECT;
                    pos_next   = 8'd0;
                end
                else
                begin
                    case (pos_reg)
                        8'd0:  vihl_next = b;
                        8'd4:  id_next[15:8] = b;
                        8'd5:  id_next[7:0] = b;
                        8'd6:  frag_next[15:8] = b;
                        8'd7:  frag_next[7:0] = b;
                        8'd9:  proto_next = b;
                        8'd12: src_next[31:24] = b;
                        8'd13: src_next[23:16] = b;
                        8'd14: src_next[15:8] = b;
                        8'd15: src_next[7:0] = b;
                        8'd16: dst_next[31:24] = b;
                        8'd17: dst_next[23:16] = b;
                        8'd18: dst_next[15:8] = b;
                        8'd19: dst_next[7:0] = b;
                        default: ;
                    endcase
                    if (pos9 >= hl9 && pos9 < hl9 + 9'd4)
                    begin
                        case (l4_off[1:0])
                            2'd0:    l4_next[31:24] = b;
                            2'd1:    l4_next[23:16] = b;
                            2'd2:    l4_next[15:8] = b;
                            default: l4_next[7:0] = b;
                        endcase
                    end
                    if (pos9 + 9'd1 >= hl9 + 9'd4)
                        phase_next = PH_IPDONE;
                end
            end
            default:
                pos_next = pos_reg;
        endcase
    end

    always_comb
    begin
        hl_n = {3'b000, vihl_next[3:0], 2'b00};
        if (phase_next == PH_IPDONE)
            l4n = 9'd4;
        else if ({1'b0, pos_next} > hl_n)
            l4n = {1'b0, pos_next} - hl_n;
        else
            l4n = 9'd0;
        if (proto_next == 8'd6 || proto_next == 8'd17)
        begin
            need  = ifkc_pkg::NEED_PORTS;
            need9 = 9'd4;
        end
        else if (proto_next == 8'd1)
        begin
            need  = ifkc_pkg::NEED_ICMP;
            need9 = 9'd2;
        end
        else
        begin
            need  = ifkc_pkg::NEED_NONE;
            need9 = 9'd0;
        end
        desc.ip_ok    = (phase_next == PH_IP || phase_next == PH_IPDONE) && pos_next >= 8'd20;
        desc.fragd    = frag_next[13:0] != 14'd0;
        desc.l4_ok    = l4n >= need9;
        desc.need     = need;
        desc.src_addr = src_next;
        desc.dst_addr = dst_next;
        desc.ip_id    = id_next;
        desc.protocol = proto_next;
        if (need == ifkc_pkg::NEED_PORTS)
        begin
            desc.source_port = l4_next[31:16];
            desc.dest_port   = l4_next[15:0];
        end
        else
        begin
            desc.source_port = {8'h00, l4_next[31:24]};
            desc.dest_port   = {8'h00, l4_next[23:16]};
        end
        desc.multicast = mc_next;
        desc.length    = byte_data.wire_length;
        desc.now_time  = byte_data.now_time;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= 16'd1500;
            phase_reg   <= PH_ETH;
            pos_reg     <= 8'd0;
            et_reg      <= 16'd0;
            mc_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                max_len_reg <= cfg_wdata;
            if (accept)
            begin
                if (byte_data.last_byte)
                begin
                    phase_reg <= PH_ETH;
                    pos_reg   <= 8'd0;
                    et_reg    <= 16'd0;
                    mc_reg    <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    pos_reg   <= pos_next;
                    et_reg    <= et_next;
                    mc_reg    <= mc_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            llc0_reg  <= llc0_next;
            llc1_reg  <= llc1_next;
            vihl_reg  <= vihl_next;
            id_reg    <= id_next;
            frag_reg  <= frag_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            l4_reg    <= l4_next;
        end
    end

endmodule

[hdl/ifkc_queue.sv]
module ifkc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ifkc_pkg::desc_t    push_data,
    output logic               not_full,
    output logic               pop_valid,
    input  logic               pop,
    output ifkc_pkg::desc_t    pop_data
);

    ifkc_pkg::desc_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign not_full  = count_reg != 2'd2;
    assign pop_valid = count_reg != 2'd0;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[hdl/ifkc_back.sv]
module ifkc_back #(
    parameter int FRAG_ENTRIES = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  ifkc_pkg::desc_t            q_data,
    output logic                       q_pop,
    output logic                       busy,
    output logic                       result_valid,
    input  logic                       result_ready,
    output ifkc_pkg::result_item_t     result_data
);

    localparam int AW = (FRAG_ENTRIES > 1) ? $clog2(FRAG_ENTRIES) : 1;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    ifkc_pkg::entry_t mem [FRAG_ENTRIES];
    ifkc_pkg::entry_t rd_data_reg;

    logic [2:0]    state_reg, state_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    logic [31:0]   low_reg, low_next;
    logic [AW-1:0] victim_reg, victim_next;
    logic          hit_reg, hit_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    ifkc_pkg::entry_t       hit_entry_reg, hit_entry_next;
    ifkc_pkg::desc_t        cur_reg, cur_next;
    ifkc_pkg::result_item_t res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    ifkc_pkg::result_item_t out_data_reg, out_data_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    ifkc_pkg::entry_t    wr_data;
    logic                dec_wr;
    logic [AW-1:0]       dec_addr;
    ifkc_pkg::entry_t    dec_entry;
    ifkc_pkg::result_item_t dec_res;
    logic                use_hit;

    assign busy         = state_reg == ST_CLEAR;
    assign q_pop        = state_reg == ST_IDLE && q_valid;
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    always_comb
    begin
        dec_res                     = '0;
        dec_res.multicast           = cur_reg.multicast;
        dec_res.length_out          = cur_reg.length;
        dec_wr                      = 1'b0;
        dec_addr                    = hit_reg ? hit_idx_reg : victim_reg;
        dec_entry.src_addr          = cur_reg.src_addr;
        dec_entry.dst_addr          = cur_reg.dst_addr;
        dec_entry.ip_id             = cur_reg.ip_id;
        dec_entry.protocol          = cur_reg.protocol;
        dec_entry.source_port       = cur_reg.source_port;
        dec_entry.dest_port         = cur_reg.dest_port;
        dec_entry.stamp             = cur_reg.now_time;
        use_hit = cur_reg.fragd && hit_reg && cur_reg.now_time != 32'd0;
        if (cur_reg.ip_ok)
        begin
            if (use_hit)
            begin
                dec_res.packet_class        = ifkc_pkg::CLASS_FLOW;
                dec_res.src_addr            = hit_entry_reg.src_addr;
                dec_res.dst_addr            = hit_entry_reg.dst_addr;
                dec_res.protocol            = hit_entry_reg.protocol;
                dec_res.source_port         = hit_entry_reg.source_port;
                dec_res.dest_port           = hit_entry_reg.dest_port;
                dec_res.from_fragment_entry = 1'b1;
                dec_entry                   = hit_entry_reg;
                dec_entry.stamp             = cur_reg.now_time;
                dec_wr                      = 1'b1;
            end
            else if (cur_reg.l4_ok)
            begin
                dec_res.src_addr = cur_reg.src_addr;
                dec_res.dst_addr = cur_reg.dst_addr;
                dec_res.protocol = cur_reg.protocol;
                dec_wr           = cur_reg.fragd;
                if (cur_reg.need == ifkc_pkg::NEED_NONE)
                begin
                    dec_res.packet_class = ifkc_pkg::CLASS_IPV4;
                    dec_entry.stamp      = 32'd0;
                end
                else
                begin
                    dec_res.packet_class = ifkc_pkg::CLASS_FLOW;
                    dec_res.source_port  = cur_reg.source_port;
                    dec_res.dest_port    = cur_reg.dest_port;
                end
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        low_next       = low_reg;
        victim_next    = victim_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_entry_next = hit_entry_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg[AW-1:0];
        wr_data        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[AW-1:0] == AW'(FRAG_ENTRIES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cur_next    = q_data;
                    cnt_next    = '0;
                    pend_next   = 1'b0;
                    hit_next    = 1'b0;
                    low_next    = 32'd0;
                    victim_next = '0;
                    if (q_data.ip_ok && q_data.fragd)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_DECIDE;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg < (AW + 1)'(FRAG_ENTRIES))
                begin
                    cnt_next      = cnt_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = cnt_reg[AW-1:0];
                end
                else
                    pend_next = 1'b0;
                if (pend_reg)
                begin
                    if (pend_idx_reg == '0 || rd_data_reg.stamp < low_reg)
                    begin
                        low_next    = rd_data_reg.stamp;
                        victim_next = pend_idx_reg;
                    end
                    if (!hit_reg && rd_data_reg.stamp != 32'd0 &&
                        rd_data_reg.src_addr == cur_reg.src_addr &&
                        rd_data_reg.dst_addr == cur_reg.dst_addr &&
                        rd_data_reg.ip_id == cur_reg.ip_id)
                    begin
                        hit_next       = 1'b1;
                        hit_idx_next   = pend_idx_reg;
                        hit_entry_next = rd_data_reg;
                    end
                    if (pend_idx_reg == AW'(FRAG_ENTRIES - 1))
                        state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                wr_en      = dec_wr;
                wr_addr    = dec_addr;
                wr_data    = dec_entry;
                res_next   = dec_res;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[cnt_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        low_reg       <= low_next;
        victim_reg    <= victim_next;
        hit_idx_reg   <= hit_idx_next;
        hit_entry_reg <= hit_entry_next;
        cur_reg       <= cur_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

endmodule

[hdl/ipv4_flow_key_classifier_core.sv]
// Ethernet/IPv4 flow key classifier. Frame bytes are taken one per cycle, with no
// gaps needed between frames, while the two-entry packet queue has room. The back
// end handles one packet at a time; for a fragment the fragment table is scanned one
// entry per cycle through its single read port. After reset the table is cleared one
// entry per cycle, during which no byte is accepted.
module ipv4_flow_key_classifier_core #(
    parameter int FRAG_ENTRIES = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_valid,
    output logic                       byte_ready,
    input  ifkc_pkg::byte_item_t       byte_data,
    output logic                       result_valid,
    input  logic                       result_ready,
    output ifkc_pkg::result_item_t     result_data,
    input  logic                       cfg_we,
    input  logic [15:0]                cfg_wdata
);

    logic            push, not_full, pop_valid, pop, busy;
    ifkc_pkg::desc_t push_desc, pop_desc;

    ifkc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_data   (byte_data),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .queue_ready (not_full),
        .table_busy  (busy),
        .push        (push),
        .desc        (push_desc)
    );

    ifkc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_desc),
        .not_full  (not_full),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_data  (pop_desc)
    );

    ifkc_back #(
        .FRAG_ENTRIES (FRAG_ENTRIES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (pop_valid),
        .q_data       (pop_desc),
        .q_pop        (pop),
        .busy         (busy),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import ifkc_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [15:0] ETH_VLAN  = 16'h8100;
    localparam logic [15:0] ETH_PPPOE = 16'h8864;
    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [7:0]  LLC_SNAP  = 8'hAA;
    localparam logic [7:0]  LLC_UI    = 8'h03;
    localparam logic [7:0]  LLC_IP    = 8'h06;
    localparam logic [7:0]  PPP_IPV4  = 8'h21;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    localparam int CAP_SRC   = 0;
    localparam int CAP_DST   = 4;
    localparam int CAP_ID    = 8;
    localparam int CAP_FRAG  = 10;
    localparam int CAP_PROTO = 12;
    localparam int CAP_VIHL  = 13;
    localparam int CAP_L4    = 14;
    localparam int CAP_LLC   = 18;

    localparam int ENC_PLAIN  = 0;
    localparam int ENC_VLAN   = 1;
    localparam int ENC_SNAP   = 2;
    localparam int ENC_LLCIP  = 3;
    localparam int ENC_PPPOE  = 4;
    localparam int ENC_VENDOR = 5;
    localparam int ENC_BADPPP = 6;
    localparam int ENC_COUNT  = 7;

    typedef enum logic [3:0] {
        PH_ETH, PH_VLAN, PH_LLC, PH_SNAP, PH_PPPOE, PH_IP, PH_IPDONE, PH_REJECT
    } parse_phase_e;

    logic           clk;
    logic           rst_n;
    logic           byte_valid;
    logic           byte_ready;
    byte_item_t     byte_data;
    logic           result_valid;
    logic           result_ready;
    result_item_t   result_data;
    logic           cfg_we;
    logic [15:0]    cfg_wdata;

    ipv4_flow_key_classifier_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    // Predictor state for the frame being parsed and the fragment table.
    logic [15:0]  max_len;
    logic [7:0]   pos;
    parse_phase_e phase;
    logic [15:0]  etype;
    logic [7:0]   cap [24];
    logic         mcast;
    logic [31:0]  ft_src   [TABLE_DEPTH];
    logic [31:0]  ft_dst   [TABLE_DEPTH];
    logic [15:0]  ft_id    [TABLE_DEPTH];
    logic [7:0]   ft_proto [TABLE_DEPTH];
    logic [15:0]  ft_sport [TABLE_DEPTH];
    logic [15:0]  ft_dport [TABLE_DEPTH];
    logic [31:0]  ft_time  [TABLE_DEPTH];

    result_item_t expected_results [$];
    logic [7:0]   frame_bytes [$];

    bit           gaps_on;
    bit           hold_req;
    int           hold_left;
    int           errors;
    int           bytes_sent;
    int           results_seen;
    int           class_count [3];
    int           table_hits;
    logic [31:0]  tnow;
    logic [31:0]  pool_src [4];
    logic [31:0]  pool_dst [4];
    logic [15:0]  pool_id  [4];

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic void go_phase(input parse_phase_e p);
        phase = p;
        pos = 8'd0;
    endfunction

    function automatic void go_tail();
        if (etype == ETH_PPPOE)
            go_phase(PH_PPPOE);
        else if (etype == ETH_IPV4)
            go_phase(PH_IP);
        else
            go_phase(PH_REJECT);
    endfunction

    function automatic void go_dispatch();
        if (etype <= max_len)
            go_phase(PH_LLC);
        else
            go_tail();
    endfunction

    function automatic void clear_frame();
        pos = 8'd0;
        phase = PH_ETH;
        etype = 16'd0;
        mcast = 1'b0;
        foreach (cap[i])
            cap[i] = 8'd0;
    endfunction

    // Parses one byte; a set return value means the three LLC bytes are parsed again.
    function automatic bit parse_byte(input logic [7:0] b);
        int p;
        int hl;
        p = pos;
        case (phase)
            PH_ETH:
            begin
                if (p == 0)
                    mcast = b[0];
                if (p == 12)
                    etype = {b, 8'd0};
                if (p == 13)
                begin
                    etype[7:0] = b;
                    if (etype == ETH_VLAN)
                        go_phase(PH_VLAN);
                    else
                        go_dispatch();
                    return 0;
                end
            end
            PH_VLAN:
            begin
                if (p == 2)
                    etype = {b, 8'd0};
                if (p == 3)
                begin
                    etype[7:0] = b;
                    go_dispatch();
                    return 0;
                end
            end
            PH_LLC:
            begin
                cap[CAP_LLC + p] = b;
                if (p == 2)
                begin
                    if (cap[CAP_LLC] == LLC_SNAP && cap[CAP_LLC + 1] == LLC_SNAP && b == LLC_UI)
                        go_phase(PH_SNAP);
                    else if (cap[CAP_LLC] == LLC_IP && cap[CAP_LLC + 1] == LLC_IP && b[0])
                    begin
                        etype = ETH_IPV4;
                        go_phase(PH_IP);
                    end
                    else
                    begin
                        go_tail();
                        return phase == PH_IP || phase == PH_PPPOE;
                    end
                    return 0;
                end
            end
            PH_SNAP:
            begin
                if (p < 3)
                begin
                    if (b != 8'd0)
                    begin
                        go_phase(PH_REJECT);
                        return 0;
                    end
                end
                else if (p == 3)
                    etype = {b, 8'd0};
                else
                begin
                    etype[7:0] = b;
                    go_tail();
                    return 0;
                end
            end
            PH_PPPOE:
            begin
                if (p == 6 && b != 8'd0)
                begin
                    go_phase(PH_REJECT);
                    return 0;
                end
                if (p == 7)
                begin
                    if (b == PPP_IPV4)
                    begin
                        etype = ETH_IPV4;
                        go_phase(PH_IP);
                    end
                    else
                        go_phase(PH_REJECT);
                    return 0;
                end
            end
            PH_IP:
            begin
                if (p == 0)
                begin
                    if (b[7:4] != 4'd4 || b[3:0] < 4'd5)
                    begin
                        go_phase(PH_REJECT);
                        return 0;
                    end
                    cap[CAP_VIHL] = b;
                end
                else if (p >= 4 && p <= 7)
                    cap[CAP_ID + p - 4] = b;
                else if (p == 9)
                    cap[CAP_PROTO] = b;
                else if (p >= 12 && p <= 19)
                    cap[CAP_SRC + p - 12] = b;
                hl = cap[CAP_VIHL][3:0] * 4;
                if (p >= hl && p < hl + 4)
                    cap[CAP_L4 + p - hl] = b;
                pos = 8'(p + 1);
                if (p + 1 >= hl + 4)
                    phase = PH_IPDONE;
                return 0;
            end
            default:
                return 0;
        endcase
        pos = 8'(p + 1);
        return 0;
    endfunction

    function automatic result_item_t classify_frame(input logic [31:0] now);
        result_item_t r;
        logic [31:0]  s;
        logic [31:0]  d;
        logic [15:0]  id;
        logic [7:0]   pr;
        logic [31:0]  low;
        logic         fragd;
        int           hl;
        int           l4n;
        int           need;
        int           hit;
        int           victim;
        int           idx;
        r = '0;
        r.multicast = mcast;
        hit = -1;
        victim = 0;
        if (!((phase == PH_IP || phase == PH_IPDONE) && pos >= 20))
            return r;
        s = {cap[CAP_SRC], cap[CAP_SRC + 1], cap[CAP_SRC + 2], cap[CAP_SRC + 3]};
        d = {cap[CAP_DST], cap[CAP_DST + 1], cap[CAP_DST + 2], cap[CAP_DST + 3]};
        id = {cap[CAP_ID], cap[CAP_ID + 1]};
        pr = cap[CAP_PROTO];
        hl = cap[CAP_VIHL][3:0] * 4;
        if (phase == PH_IPDONE)
            l4n = 4;
        else
            l4n = (pos > hl) ? pos - hl : 0;
        fragd = ({cap[CAP_FRAG], cap[CAP_FRAG + 1]} & 16'h3FFF) != 16'd0;
        if (fragd)
        begin
            low = ft_time[0];
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (ft_time[i] < low)
                begin
                    low = ft_time[i];
                    victim = i;
                end
                if (hit < 0 && ft_time[i] != 0 && ft_src[i] == s && ft_dst[i] == d
                    && ft_id[i] == id)
                    hit = i;
            end
        end
        if (fragd && hit >= 0 && now != 0)
        begin
            ft_time[hit] = now;
            r.packet_class = CLASS_FLOW;
            r.src_addr = ft_src[hit];
            r.dst_addr = ft_dst[hit];
            r.protocol = ft_proto[hit];
            r.source_port = ft_sport[hit];
            r.dest_port = ft_dport[hit];
            r.from_fragment_entry = 1'b1;
            table_hits++;
            return r;
        end
        if (pr == PROTO_TCP || pr == PROTO_UDP)
            need = 4;
        else if (pr == PROTO_ICMP)
            need = 2;
        else
            need = 0;
        if (l4n < need)
            return r;
        idx = fragd ? (hit >= 0 ? hit : victim) : -1;
        r.src_addr = s;
        r.dst_addr = d;
        r.protocol = pr;
        if (need == 0)
        begin
            r.packet_class = CLASS_IPV4;
            if (idx >= 0)
                ft_time[idx] = 32'd0;
            return r;
        end
        r.packet_class = CLASS_FLOW;
        if (need == 4)
        begin
            r.source_port = {cap[CAP_L4], cap[CAP_L4 + 1]};
            r.dest_port = {cap[CAP_L4 + 2], cap[CAP_L4 + 3]};
        end
        else
        begin
            r.source_port = {8'd0, cap[CAP_L4]};
            r.dest_port = {8'd0, cap[CAP_L4 + 1]};
        end
        if (idx >= 0)
        begin
            ft_src[idx] = s;
            ft_dst[idx] = d;
            ft_id[idx] = id;
            ft_proto[idx] = pr;
            ft_sport[idx] = r.source_port;
            ft_dport[idx] = r.dest_port;
            ft_time[idx] = now;
        end
        return r;
    endfunction

    function automatic void predict_byte(input byte_item_t it);
        result_item_t r;
        if (parse_byte(it.data_byte))
        begin
            void'(parse_byte(cap[CAP_LLC]));
            void'(parse_byte(cap[CAP_LLC + 1]));
            void'(parse_byte(cap[CAP_LLC + 2]));
        end
        if (it.last_byte)
        begin
            r = classify_frame(it.now_time);
            r.length_out = it.wire_length;
            class_count[r.packet_class]++;
            expected_results.push_back(r);
            clear_frame();
        end
    endfunction

    task automatic send_byte(input byte_item_t it);
        if (gaps_on && $urandom_range(99) < 13)
        begin
            byte_valid <= 1'b0;
            do
                @(posedge clk);
            while (gaps_on && $urandom_range(99) < 40);
        end
        byte_valid <= 1'b1;
        byte_data <= it;
        do
            @(posedge clk);
        while (!byte_ready);
        predict_byte(it);
        bytes_sent++;
    endtask

    function automatic logic [31:0] next_time();
        int r;
        r = $urandom_range(99);
        tnow = tnow + $urandom_range(1, 3);
        if (r < 4)
            return 32'd0;
        if (r < 7)
            return $urandom;
        return tnow;
    endfunction

    task automatic send_frame(input int keep);
        byte_item_t  it;
        int          n;
        logic [15:0] wl;
        logic [31:0] t;
        n = (keep > 0 && keep < frame_bytes.size()) ? keep : frame_bytes.size();
        wl = $urandom;
        t = next_time();
        for (int i = 0; i < n; i++)
        begin
            it.data_byte = frame_bytes[i];
            it.last_byte = (i == n - 1);
            it.wire_length = wl;
            it.now_time = t;
            send_byte(it);
        end
    endtask

    task automatic put16(input logic [15:0] v);
        frame_bytes.push_back(v[15:8]);
        frame_bytes.push_back(v[7:0]);
    endtask

    task automatic put32(input logic [31:0] v);
        put16(v[31:16]);
        put16(v[15:0]);
    endtask

    task automatic make_frame(input int enc, input logic [7:0] vihl, input logic [7:0] proto,
                              input logic [15:0] id, input logic [15:0] fragw,
                              input logic [31:0] s, input logic [31:0] d);
        logic [15:0] len;
        len = 16'($urandom_range(0, max_len));
        frame_bytes.delete();
        repeat (12)
            frame_bytes.push_back($urandom);
        case (enc)
            ENC_VLAN:
            begin
                put16(ETH_VLAN);
                put16($urandom);
                put16(ETH_IPV4);
            end
            ENC_SNAP, ENC_VENDOR:
            begin
                put16(len);
                frame_bytes.push_back(LLC_SNAP);
                frame_bytes.push_back(LLC_SNAP);
                frame_bytes.push_back(LLC_UI);
                put16(16'd0);
                frame_bytes.push_back(enc == ENC_VENDOR ? 8'h0C : 8'h00);
                put16(ETH_IPV4);
            end
            ENC_LLCIP:
            begin
                put16(len);
                frame_bytes.push_back(LLC_IP);
                frame_bytes.push_back(LLC_IP);
                frame_bytes.push_back(LLC_UI);
            end
            ENC_PPPOE, ENC_BADPPP:
            begin
                put16(ETH_PPPOE);
                put32($urandom);
                put16($urandom);
                frame_bytes.push_back(8'h00);
                frame_bytes.push_back(enc == ENC_BADPPP ? 8'h57 : PPP_IPV4);
            end
            default:
                put16(ETH_IPV4);
        endcase
        frame_bytes.push_back(vihl);
        frame_bytes.push_back($urandom);
        put16($urandom);
        put16(id);
        put16(fragw);
        frame_bytes.push_back($urandom);
        frame_bytes.push_back(proto);
        put16($urandom);
        put32(s);
        put32(d);
        repeat ((vihl[3:0] > 5) ? (vihl[3:0] - 5) * 4 : 0)
            frame_bytes.push_back($urandom);
        put32($urandom);
        repeat ($urandom_range(0, 6))
            frame_bytes.push_back($urandom);
    endtask

    task automatic drain();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_max_len(input logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        max_len = v;
    endtask

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(3))
            0: return PROTO_TCP;
            1: return PROTO_UDP;
            2: return PROTO_ICMP;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_frame();
        int          k;
        int          enc;
        logic [7:0]  vihl;
        logic [15:0] id;
        logic [15:0] fragw;
        logic [31:0] s;
        logic [31:0] d;
        if ($urandom_range(99) < 12)
        begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 30))
                frame_bytes.push_back($urandom);
            send_frame(0);
            return;
        end
        enc = $urandom_range(99) < 50 ? ENC_PLAIN : $urandom_range(ENC_COUNT - 1);
        vihl = {4'd4, $urandom_range(99) < 70 ? 4'd5 : 4'($urandom_range(5, 15))};
        if ($urandom_range(99) < 5)
            vihl = $urandom;
        if ($urandom_range(99) < 40)
        begin
            k = $urandom_range(3);
            s = pool_src[k];
            d = pool_dst[k];
            id = pool_id[k];
            fragw = {$urandom_range(3), 14'($urandom)} | 16'h2000;
        end
        else
        begin
            s = $urandom;
            d = $urandom;
            id = $urandom;
            fragw = $urandom_range(1) ? 16'h4000 : 16'($urandom);
        end
        make_frame(enc, vihl, pick_proto(), id, fragw, s, d);
        send_frame($urandom_range(99) < 15 ? $urandom_range(1, frame_bytes.size()) : 0);
    endtask

    task automatic test_encapsulations();
        gaps_on = 1'b0;
        make_frame(ENC_PLAIN, 8'h45, PROTO_TCP, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 32'h0);
        send_frame(0);
        make_frame(ENC_VLAN, 8'h4F, PROTO_UDP, 16'hFFFF, 16'h4000, 32'h0, 32'hFFFF_FFFF);
        send_frame(0);
        make_frame(ENC_SNAP, 8'h45, PROTO_ICMP, 16'h1234, 16'h0000, $urandom, $urandom);
        send_frame(0);
        make_frame(ENC_LLCIP, 8'h46, 8'd47, 16'h1, 16'h0, $urandom, $urandom);
        send_frame(0);
        make_frame(ENC_PPPOE, 8'h45, PROTO_TCP, 16'h2, 16'h0, $urandom, $urandom);
        send_frame(0);
        make_frame(ENC_VENDOR, 8'h45, PROTO_TCP, 16'h3, 16'h0, $urandom, $urandom);
        send_frame(0);
        make_frame(ENC_BADPPP, 8'h45, PROTO_UDP, 16'h4, 16'h0, $urandom, $urandom);
        send_frame(0);
        make_frame(ENC_PLAIN, 8'h44, PROTO_TCP, 16'h5, 16'h0, $urandom, $urandom);
        send_frame(0);
        make_frame(ENC_PLAIN, 8'h65, PROTO_TCP, 16'h6, 16'h0, $urandom, $urandom);
        send_frame(0);
        make_frame(ENC_PLAIN, 8'h45, PROTO_TCP, 16'h7, 16'h0, $urandom, $urandom);
        send_frame(30);
        send_frame(36);
        send_frame(1);
        make_frame(ENC_PLAIN, 8'h45, PROTO_ICMP, 16'h8, 16'h0, $urandom, $urandom);
        send_frame(36);
        gaps_on = 1'b1;
    endtask

    task automatic test_fragment_table();
        for (int i = 0; i < TABLE_DEPTH + 6; i++)
        begin
            make_frame(ENC_PLAIN, 8'h45, i % 5 == 4 ? 8'd50 : pick_proto(), 16'(i),
                       16'h2000, 32'h0A00_0001, 32'h0A00_0002);
            send_frame(0);
        end
        for (int i = 0; i < 12; i++)
        begin
            make_frame(ENC_PLAIN, 8'h45, 8'd99, 16'($urandom_range(0, TABLE_DEPTH + 5)),
                       16'h00B9, 32'h0A00_0001, 32'h0A00_0002);
            send_frame($urandom_range(1) ? 0 : 34);
        end
    endtask

    task automatic test_length_limit();
        logic [15:0] limits [4];
        limits = '{16'd0, 16'hFFFF, ETH_IPV4, 16'd1500};
        foreach (limits[j])
        begin
            write_max_len(limits[j]);
            for (int i = 0; i < ENC_COUNT; i++)
            begin
                make_frame(i, 8'h45, pick_proto(), $urandom, 16'h0, $urandom, $urandom);
                send_frame(0);
            end
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++)
            random_frame();
        drain();
        for (int i = 0; i < 4; i++)
            random_frame();
    endtask

    task automatic test_random_traffic();
        int start_bytes;
        int start_results;
        start_bytes = bytes_sent;
        start_results = results_seen + expected_results.size();
        foreach (pool_src[k])
        begin
            pool_src[k] = $urandom;
            pool_dst[k] = $urandom;
            pool_id[k] = $urandom;
        end
        while (bytes_sent - start_bytes < 500
               || results_seen + expected_results.size() - start_results < 60)
        begin
            if ($urandom_range(99) < 3)
                write_max_len($urandom_range(1) ? 16'd1500 : 16'($urandom));
            random_frame();
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= !(gaps_on && $urandom_range(99) < 13);
        end
    end

    always @(posedge clk)
    begin
        result_item_t e;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result %p", result_data);
            end
            else
            begin
                e = expected_results.pop_front();
                results_seen++;
                if (result_data.packet_class !== e.packet_class
                    || result_data.src_addr !== e.src_addr
                    || result_data.dst_addr !== e.dst_addr
                    || result_data.protocol !== e.protocol
                    || result_data.source_port !== e.source_port
                    || result_data.dest_port !== e.dest_port
                    || result_data.multicast !== e.multicast
                    || result_data.from_fragment_entry !== e.from_fragment_entry
                    || result_data.length_out !== e.length_out)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: result %0d expected %p actual %p",
                                 results_seen, e, result_data);
                end
            end
        end
    end

    initial
    begin
        #4ms;
        $display("ERROR: timeout with %0d results outstanding", expected_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = 16'd0;
        gaps_on = 1'b1;
        hold_req = 1'b0;
        hold_left = 0;
        errors = 0;
        bytes_sent = 0;
        results_seen = 0;
        table_hits = 0;
        tnow = 32'd1;
        class_count = '{0, 0, 0};
        max_len = 16'd1500;
        clear_frame();
        for (int i = 0; i < TABLE_DEPTH; i++)
            ft_time[i] = 32'd0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        test_encapsulations();
        test_fragment_table();
        test_length_limit();
        test_backpressure();
        test_random_traffic();
        drain();
        while (expected_results.size() != 0)
            @(posedge clk);
        $display("Sent %0d bytes, checked %0d results (class 0/1/2: %0d/%0d/%0d).",
                 bytes_sent, results_seen, class_count[0], class_count[1], class_count[2]);
        $display("Fragment table supplied %0d keys; %0d mismatches.", table_hits, errors);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
